FILE: rtl/sact_pkg.sv
// Package: geometry, field widths and policy codes of the cache tag store.
`timescale 1ns / 1ps
package sact_pkg;
    localparam int WAYS = 4;
    localparam int SETS = 64;
    localparam int BLOCK_BYTES = 32;
    localparam int OFF_BITS = $clog2(BLOCK_BYTES);
    localparam int SET_BITS = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int SET_USED = $clog2(SETS);
    localparam int TAG_BITS = 32 - OFF_BITS - SET_USED;
    localparam int WAY_BITS = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int TIME_BITS = 48;
    localparam int USE_BITS = 16;
    localparam int CNT_BITS = 40;

    localparam logic [1:0] POL_LRU = 2'd0;
    localparam logic [1:0] POL_FIFO = 2'd1;
    localparam logic [1:0] POL_LFU = 2'd2;
    // spare code: a full set always gives up way 0
    localparam logic [1:0] POL_UNUSED = 2'd3;

    typedef struct packed {
        logic [TAG_BITS-1:0]  tag;
        logic [TIME_BITS-1:0] last_use;
        logic [TIME_BITS-1:0] arrival;
        logic [USE_BITS-1:0]  use_cnt;
    } line_t;

    typedef line_t [WAYS-1:0] set_row_t;
endpackage

FILE: rtl/set_assoc_cache_tag_replacement.sv
// Top level: set-associative tag store with LRU, FIFO and LFU replacement.
`timescale 1ns / 1ps
//  channel  | signals                                      | dir
//  ---------+----------------------------------------------+----
//  request  | in_valid, in_stall, address                  | in
//  result   | out_valid, out_stall, hit, way, replaced_valid,| out
//           | hit_count, miss_count                        |
//  config   | cfg_valid, cfg_ready, cfg_data               | in
//
// Each request runs these steps in order: accept and read the set row from the
// line memory, decide hit/victim on the registered row, write back and load
// the result register. The row read is registered, and the write-back goes to the
// same set; requests are handled one at a time.
// Reset clears valid bits (256 flops), counters and the clock; the line memory
// itself is not cleared. A stalled result holds; a new request is taken while
// the result waits, and its result is loaded once the old one is taken.
module set_assoc_cache_tag_replacement (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] address,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        hit,
    output logic [1:0]  way,
    output logic        replaced_valid,
    output logic [39:0] hit_count,
    output logic [39:0] miss_count,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_data
);
    import sact_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0] state_reg, state_next;
    logic [1:0] policy_reg;
    logic [SET_BITS-1:0] set_reg;
    logic [TAG_BITS-1:0] tag_reg;
    logic [TIME_BITS-1:0] clock_reg;
    logic [CNT_BITS-1:0] hits_reg, misses_reg;
    logic [WAYS-1:0] valid_reg [SETS];
    set_row_t mem [SETS];
    set_row_t row_reg;
    logic out_valid_reg;

    logic [SET_BITS-1:0] in_set;
    logic [TAG_BITS-1:0] in_tag;
    logic [WAY_BITS-1:0] victim;
    logic accept;

    assign in_set = (SETS > 1) ? SET_BITS'(address >> OFF_BITS) : '0;
    assign in_tag = TAG_BITS'(address >> (OFF_BITS + SET_USED));
    assign in_stall = (state_reg != ST_IDLE);
    assign accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;

    sact_victim u_victim (.policy(policy_reg), .row(row_reg), .victim(victim));

    // lookup on the registered row
    logic [WAYS-1:0] vrow;
    logic l_hit, l_empty;
    logic [WAY_BITS-1:0] hit_way, empty_way, l_way;
    logic [TIME_BITS-1:0] now;
    set_row_t row_new;

    always_comb
    begin
        vrow = valid_reg[set_reg];
        now = (clock_reg == {TIME_BITS{1'b1}}) ? clock_reg : clock_reg + 1'b1;
        l_hit = 1'b0;
        l_empty = 1'b0;
        hit_way = '0;
        empty_way = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (vrow[w] && row_reg[w].tag == tag_reg)
            begin
                l_hit = 1'b1;
                hit_way = WAY_BITS'(w);
            end
            if (!vrow[w])
            begin
                l_empty = 1'b1;
                empty_way = WAY_BITS'(w);
            end
        end
        l_way = l_hit ? hit_way : (l_empty ? empty_way : victim);
        row_new = row_reg;
        row_new[l_way].last_use = now;
        if (l_hit)
        begin
            if (row_reg[l_way].use_cnt != {USE_BITS{1'b1}})
                row_new[l_way].use_cnt = row_reg[l_way].use_cnt + 1'b1;
        end
        else
        begin
            row_new[l_way].tag = tag_reg;
            row_new[l_way].arrival = now;
            row_new[l_way].use_cnt = USE_BITS'(1);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept) state_next = ST_READ;
            ST_READ: state_next = ST_DONE;
            ST_DONE: if (!out_valid_reg || !out_stall) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // line memory: read a row on accept, write it back when done
    always_ff @(posedge clk)
    begin
        if (accept)
            row_reg <= mem[in_set];
        if (state_reg == ST_DONE && (!out_valid_reg || !out_stall))
            mem[set_reg] <= row_new;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            set_reg <= in_set;
            tag_reg <= in_tag;
        end
    end

    logic finish;
    assign finish = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            policy_reg <= POL_LRU;
            clock_reg <= '0;
            hits_reg <= '0;
            misses_reg <= '0;
            out_valid_reg <= 1'b0;
            hit <= 1'b0;
            way <= '0;
            replaced_valid <= 1'b0;
            hit_count <= '0;
            miss_count <= '0;
            for (int s = 0; s < SETS; s++)
                valid_reg[s] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
                policy_reg <= cfg_data;
            // drop a taken result unless a new one replaces it this cycle
            if (out_valid_reg && !out_stall && !finish)
                out_valid_reg <= 1'b0;
            if (finish)
            begin
                clock_reg <= now;
                valid_reg[set_reg][l_way] <= 1'b1;
                out_valid_reg <= 1'b1;
                hit <= l_hit;
                way <= 2'(l_way);
                replaced_valid <= !l_hit && !l_empty;
                if (l_hit)
                begin
                    if (hits_reg != {CNT_BITS{1'b1}})
                        hits_reg <= hits_reg + 1'b1;
                    hit_count <= (hits_reg != {CNT_BITS{1'b1}}) ?
                                 hits_reg + 1'b1 : hits_reg;
                    miss_count <= misses_reg;
                end
                else
                begin
                    if (misses_reg != {CNT_BITS{1'b1}})
                        misses_reg <= misses_reg + 1'b1;
                    miss_count <= (misses_reg != {CNT_BITS{1'b1}}) ?
                                  misses_reg + 1'b1 : misses_reg;
                    hit_count <= hits_reg;
                end
            end
        end
    end
endmodule

FILE: rtl/sact_victim.sv
// Victim selection over the ways of one set, by replacement policy.
`timescale 1ns / 1ps
module sact_victim (
    input  logic [1:0]              policy,
    input  sact_pkg::set_row_t      row,
    output logic [sact_pkg::WAY_BITS-1:0] victim
);
    import sact_pkg::*;

    always_comb
    begin
        logic [WAY_BITS-1:0] best;
        logic beat;
        best = '0;
        for (int w = 1; w < WAYS; w++)
        begin
            case (policy)
                POL_LRU:  beat = row[w].last_use < row[best].last_use;
                POL_FIFO: beat = row[w].arrival < row[best].arrival;
                POL_LFU:  beat = (row[w].use_cnt != row[best].use_cnt) ?
                                 (row[w].use_cnt < row[best].use_cnt) :
                                 (row[w].last_use < row[best].last_use);
                default:  beat = 1'b0;
            endcase
            if (beat)
                best = WAY_BITS'(w);
        end
        victim = best;
    end
endmodule

FILE: dv/tb_set_assoc_cache_tag_replacement.sv
// Testbench: random and directed access streams against a tag store predictor.
`timescale 1ns / 1ps
module tb_set_assoc_cache_tag_replacement;
    import sact_pkg::*;

    // Expected result of one request.
    typedef struct {
        logic        hit;
        logic [1:0]  way;
        logic        replaced_valid;
        logic [39:0] hit_count;
        logic [39:0] miss_count;
    } lookup_res_t;

    // Scoreboard: predicts the tag store and holds pending lookups.
    class lookup_scoreboard;
        logic [1:0]           policy;
        bit                   vld[SETS][WAYS];
        logic [TAG_BITS-1:0]  tag_q[SETS][WAYS];
        logic [TIME_BITS-1:0] last_q[SETS][WAYS];
        logic [TIME_BITS-1:0] arr_q[SETS][WAYS];
        logic [USE_BITS-1:0]  use_q[SETS][WAYS];
        logic [TIME_BITS-1:0] now;
        logic [CNT_BITS-1:0]  hits, misses;
        lookup_res_t          pending[$];
        int                   errors;

        function new();
            policy = POL_LRU;
            now = '0;
            hits = '0;
            misses = '0;
            errors = 0;
            foreach (vld[s, w]) vld[s][w] = 0;
        endfunction

        function bit older(int s, int c, int b);
            case (policy)
                POL_LRU:  return last_q[s][c] < last_q[s][b];
                POL_FIFO: return arr_q[s][c] < arr_q[s][b];
                POL_LFU:
                    if (use_q[s][c] != use_q[s][b]) return use_q[s][c] < use_q[s][b];
                    else return last_q[s][c] < last_q[s][b];
                default:  return 0;
            endcase
        endfunction

        // Note an accepted request and queue its predicted result.
        function void note_access(logic [31:0] a);
            int s, w, sel, empty;
            logic [TAG_BITS-1:0] t;
            lookup_res_t r;
            s = (a >> OFF_BITS) % SETS;
            t = a >> (OFF_BITS + SET_USED);
            sel = -1;
            empty = -1;
            r.replaced_valid = 0;
            if (now != '1) now++;
            for (w = 0; w < WAYS; w++)
            begin
                if (vld[s][w] && sel < 0 && tag_q[s][w] == t) sel = w;
                else if (!vld[s][w] && empty < 0 && sel < 0) empty = w;
            end
            if (sel >= 0)
            begin
                r.hit = 1;
                if (hits != '1) hits++;
                last_q[s][sel] = now;
                if (use_q[s][sel] != '1) use_q[s][sel]++;
            end
            else
            begin
                r.hit = 0;
                if (misses != '1) misses++;
                if (empty >= 0) sel = empty;
                else
                begin
                    sel = 0;
                    for (w = 1; w < WAYS; w++) if (older(s, w, sel)) sel = w;
                    r.replaced_valid = 1;
                end
                vld[s][sel] = 1;
                tag_q[s][sel] = t;
                last_q[s][sel] = now;
                arr_q[s][sel] = now;
                use_q[s][sel] = 1;
            end
            r.way = sel[1:0];
            r.hit_count = hits;
            r.miss_count = misses;
            pending.insert(pending.size(), r);
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] exp_v);
            errors++;
            $display("mismatch %s: got %0h expected %0h at %0t", what, got, exp_v, $time);
        endtask

        // Check one accepted result against the oldest prediction.
        task check_result(lookup_res_t g);
            lookup_res_t e;
            if (pending.size() == 0)
            begin
                report("unexpected result", 64'd1, 64'd0);
                return;
            end
            e = pending.pop_front();
            if (g.hit !== e.hit) report("hit", g.hit, e.hit);
            if (g.way !== e.way) report("way", g.way, e.way);
            if (g.replaced_valid !== e.replaced_valid)
                report("replaced_valid", g.replaced_valid, e.replaced_valid);
            if (g.hit_count !== e.hit_count) report("hit_count", g.hit_count, e.hit_count);
            if (g.miss_count !== e.miss_count) report("miss_count", g.miss_count, e.miss_count);
        endtask
    endclass

    logic        clk, rst_n;
    logic        in_valid, in_stall;
    logic [31:0] address;
    logic        out_valid, out_stall;
    logic        hit, replaced_valid;
    logic [1:0]  way;
    logic [39:0] hit_count, miss_count;
    logic        cfg_valid, cfg_ready;
    logic [1:0]  cfg_data;

    lookup_scoreboard sb;
    int  send_idle_pct, recv_stall_pct;
    bit  hold_off;     // long receiver hold-off in progress
    int  pick_tags[4]; // small tag pool so sets fill and hit

    set_assoc_cache_tag_replacement u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .address(address),
        .out_valid(out_valid), .out_stall(out_stall),
        .hit(hit), .way(way), .replaced_valid(replaced_valid),
        .hit_count(hit_count), .miss_count(miss_count),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // Bound the run well past the slowest legal pace.
    initial
    begin
        #20ms;
        $display("TEST FAILED");
        $finish;
    end

    // Receiver: stall at random, or hold off entirely when asked.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
    end

    // Take each result at the edge where it is accepted.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result('{hit, way, replaced_valid, hit_count, miss_count});
    end

    // Offer one request; hold it until the block takes it.
    task automatic send_access(logic [31:0] a);
        do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        in_valid <= 1'b1;
        address <= a;
        do @(posedge clk); while (in_stall);
        sb.note_access(a);
        in_valid <= 1'b0;
    endtask

    // Wait for every predicted result, then let the pipeline drain.
    task automatic drain();
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_policy(logic [1:0] p);
        cfg_valid <= 1'b1;
        cfg_data <= p;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.policy = p;
    endtask

    // Build an address from set and tag, with a random byte offset.
    function automatic logic [31:0] make_addr(int s, logic [TAG_BITS-1:0] t);
        return {t, s[SET_USED-1:0], OFF_BITS'($urandom)};
    endfunction

    // Mostly reuse a small tag pool in a few sets; sometimes fully random.
    task automatic random_phase(int n);
        int k, s;
        for (k = 0; k < n; k++)
        begin
            s = $urandom_range(3);
            if ($urandom_range(9) == 0)
                send_access($urandom);
            else
                send_access(make_addr(s, TAG_BITS'(pick_tags[$urandom_range(3)]
                                                  + $urandom_range(2))));
        end
    endtask

    initial
    begin
        int k, p;
        sb = new();
        rst_n = 0;
        in_valid = 0;
        address = '0;
        cfg_valid = 0;
        cfg_data = POL_LRU;
        hold_off = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        foreach (pick_tags[k]) pick_tags[k] = $urandom;
        repeat (11) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: address extremes, fill a set then evict under LRU.
        write_policy(POL_LRU);
        send_access(32'h0000_0000);
        send_access(32'hFFFF_FFFF);
        send_access(32'h0000_0000);
        for (k = 1; k <= 5; k++) send_access(make_addr(5, TAG_BITS'(k)));
        send_access(make_addr(5, TAG_BITS'(3)));
        send_access(make_addr(5, TAG_BITS'(7)));
        drain();
        // FIFO ignores the hit that LRU would honor.
        write_policy(POL_FIFO);
        send_access(make_addr(5, TAG_BITS'(3)));
        send_access(make_addr(5, TAG_BITS'(8)));
        send_access(make_addr(5, TAG_BITS'(9)));
        drain();
        // LFU: bump one line's count, then evict the least used.
        write_policy(POL_LFU);
        send_access(make_addr(5, TAG_BITS'(9)));
        send_access(make_addr(5, TAG_BITS'(9)));
        send_access(make_addr(5, TAG_BITS'(10)));
        send_access(make_addr(5, TAG_BITS'(11)));
        drain();
        // Unused code: victim is always way 0.
        write_policy(POL_UNUSED);
        send_access(make_addr(5, TAG_BITS'(12)));
        send_access(make_addr(5, TAG_BITS'(13)));
        drain();

        // Random phases across policies and idling mixes.
        for (p = 0; p < 8; p++)
        begin
            write_policy(p[1:0]);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
                default: begin send_idle_pct = 16; recv_stall_pct = 16; end
            endcase
            if (p == 4)
            begin
                // Hold the receiver off while requests keep coming.
                fork
                    begin
                        hold_off = 1;
                        repeat (60) @(posedge clk);
                        hold_off = 0;
                    end
                    random_phase(20);
                join
            end
            random_phase(60);
            drain();
        end

        send_idle_pct = 0;
        recv_stall_pct = 0;
        drain();
        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
